// ----- rtl/core/sfd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared widths, constants and the parser phase type of the frame decoder.
// ---------------------------------------------------------------------------
package sfd_pkg;

   localparam int BYTE_W = 8;
   localparam int FUNC_W = 16;
   localparam int CNT_W  = 6;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hFE;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_FUNC_HI,
      PH_FUNC_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA,
      PH_CHECK,
      PH_EMIT
   } sfd_phase_type;

endpackage

// ----- rtl/core/sfd_req_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_req_if
// Received byte channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sfd_req_if import sfd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfd_rsp_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_rsp_if
// Decoded frame result channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sfd_rsp_if import sfd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] frame_function;
   logic [CNT_W-1:0]  frame_length;
   logic [CNT_W-1:0]  byte_index;
   logic [BYTE_W-1:0] payload_byte;
   logic              has_payload;
   logic              last;

   modport source (output valid, output frame_function, output frame_length,
                   output byte_index, output payload_byte, output has_payload,
                   output last, input ready);
   modport sink   (input valid, input frame_function, input frame_length,
                   input byte_index, input payload_byte, input has_payload,
                   input last, output ready);
endinterface

// ----- rtl/core/sfd_payload_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfd_payload_ram
// Payload byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sfd_payload_ram import sfd_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BYTE_W-1:0]        rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/serial_frame_decoder_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_frame_decoder_core
// Start byte / function / length / payload / XOR checksum frame parser.
// Header and payload bytes are taken one per cycle. After a matching
// checksum byte each result is a payload store read, then an output
// register load; a read waits for the previous load and a free output
// register. No byte is taken until the last result is loaded.
// Synchronous active-high reset clears the control state and sets the start
// byte to 0xFE; the payload store is not cleared.
// ---------------------------------------------------------------------------
module serial_frame_decoder_core import sfd_pkg::*; #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata,
   sfd_req_if.sink           req_ch,
   sfd_rsp_if.source         rsp_ch
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD);
   localparam logic [BYTE_W:0] MAX_LO = (BYTE_W+1)'(MAX_PAYLOAD);

   sfd_phase_type     state_ff, state_in;
   logic [BYTE_W-1:0] start_byte_ff;
   logic [BYTE_W-1:0] csum_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [BYTE_W-1:0] len_hi_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [LEN_W-1:0]  fill_ff;
   logic [LEN_W-1:0]  idx_ff;
   logic              rd_pend_ff;

   logic              rsp_valid_ff;
   logic [FUNC_W-1:0] rsp_func_ff;
   logic [CNT_W-1:0]  rsp_len_ff;
   logic [CNT_W-1:0]  rsp_idx_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_has_ff;
   logic              rsp_last_ff;

   logic [BYTE_W-1:0] b;
   logic              req_fire;
   logic              rsp_fire;
   logic              issue;
   logic              load;
   logic              last_now;
   logic              len_zero;
   logic              oversize;
   logic [LEN_W:0]    fill_nx;
   logic [LEN_W:0]    idx_nx;
   logic              mem_we;
   logic [BYTE_W-1:0] mem_rdata;

   assign b        = req_ch.rx_byte;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_valid_ff && rsp_ch.ready;
   assign fill_nx  = {1'b0, fill_ff} + (LEN_W+1)'(1);
   assign idx_nx   = {1'b0, idx_ff} + (LEN_W+1)'(1);
   assign len_zero = (len_hi_ff == '0) && (b == '0);
   assign oversize = (len_hi_ff != '0) || ({1'b0, b} >= MAX_LO);
   assign last_now = (length_ff == '0) || (idx_nx == {1'b0, length_ff});
   assign load     = rd_pend_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PH_HUNT: begin
            if (req_fire && b == start_byte_ff) state_in = PH_FUNC_HI;
         end
         PH_FUNC_HI: begin
            if (req_fire) state_in = PH_FUNC_LO;
         end
         PH_FUNC_LO: begin
            if (req_fire) state_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if (req_fire) state_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (req_fire) begin
               priority if (len_zero) state_in = PH_CHECK;
               else if (oversize)    state_in = PH_HUNT;
               else                  state_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (req_fire && fill_nx == {1'b0, length_ff}) state_in = PH_CHECK;
         end
         PH_CHECK: begin
            if (req_fire) state_in = (csum_ff == b) ? PH_EMIT : PH_HUNT;
         end
         PH_EMIT: begin
            if (load && last_now) state_in = PH_HUNT;
         end
         default: state_in = PH_HUNT;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready = (state_ff != PH_EMIT);
      mem_we       = (state_ff == PH_DATA) && req_fire;
      // a read goes out only when the output register is free by the load cycle
      issue        = (state_ff == PH_EMIT) && !rd_pend_ff &&
                     (!rsp_valid_ff || rsp_ch.ready);
   end

   sfd_payload_ram #(
      .DEPTH (MAX_PAYLOAD)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (fill_ff),
      .wr_data (b),
      .rd_en   (issue),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PH_HUNT;
         start_byte_ff <= START_BYTE_RESET;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= issue;
         if (csr_we) begin
            start_byte_ff <= csr_wdata;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // header, checksum and counters
   always_ff @(posedge clock) begin
      if (req_fire) begin
         unique case (state_ff)
            PH_HUNT: begin
               csum_ff <= b;
            end
            PH_FUNC_HI: begin
               func_ff[FUNC_W-1:BYTE_W] <= b;
               csum_ff                  <= csum_ff ^ b;
            end
            PH_FUNC_LO: begin
               func_ff[BYTE_W-1:0] <= b;
               csum_ff             <= csum_ff ^ b;
            end
            PH_LEN_HI: begin
               len_hi_ff <= b;
               csum_ff   <= csum_ff ^ b;
            end
            PH_LEN_LO: begin
               length_ff <= b[LEN_W-1:0];
               fill_ff   <= '0;
               csum_ff   <= csum_ff ^ b;
            end
            PH_DATA: begin
               fill_ff <= fill_nx[LEN_W-1:0];
               csum_ff <= csum_ff ^ b;
            end
            PH_CHECK: begin
               idx_ff <= '0;
            end
            default: begin
            end
         endcase
      end else if (load) begin
         idx_ff <= idx_nx[LEN_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_func_ff <= func_ff;
         rsp_len_ff  <= CNT_W'(length_ff);
         rsp_idx_ff  <= CNT_W'(idx_ff);
         rsp_has_ff  <= (length_ff != '0);
         rsp_byte_ff <= (length_ff != '0) ? mem_rdata : '0;
         rsp_last_ff <= last_now;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.frame_function = rsp_func_ff;
   assign rsp_ch.frame_length   = rsp_len_ff;
   assign rsp_ch.byte_index     = rsp_idx_ff;
   assign rsp_ch.payload_byte   = rsp_byte_ff;
   assign rsp_ch.has_payload    = rsp_has_ff;
   assign rsp_ch.last           = rsp_last_ff;

endmodule

// ----- test/frame_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_checker
// Watches the byte and result channels of the frame decoder. It parses the
// accepted bytes with its own copy of the frame state, queues the results
// each validated frame should produce, and compares every accepted result
// with the oldest one waiting.
// ---------------------------------------------------------------------------
module frame_checker import sfd_pkg::*; #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata,
   sfd_req_if                req_mon,
   sfd_rsp_if                rsp_mon,
   output int                mismatch_count,
   output int                pending_results,
   output int                results_checked,
   output int                frames_checked
);

   localparam int PRINT_LIMIT = 30;

   typedef struct packed {
      logic [FUNC_W-1:0] frame_function;
      logic [CNT_W-1:0]  frame_length;
      logic [CNT_W-1:0]  byte_index;
      logic [BYTE_W-1:0] payload_byte;
      logic              has_payload;
      logic              last;
   } frame_result_type;

   sfd_phase_type     phase;
   logic [BYTE_W-1:0] start_byte;
   logic [FUNC_W-1:0] function_code;
   logic [15:0]       length_field;
   int                fill_index;
   logic [BYTE_W-1:0] running_sum;
   logic [BYTE_W-1:0] payload_store [MAX_PAYLOAD];
   frame_result_type  decoded_q [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // queue the results of a frame whose checksum byte matched
   task automatic queue_frame();
      frame_result_type r;
      int               k;
      r.frame_function = function_code;
      if (length_field == 0) begin
         r.frame_length = '0;
         r.byte_index   = '0;
         r.payload_byte = '0;
         r.has_payload  = 1'b0;
         r.last         = 1'b1;
         decoded_q.push_back(r);
      end else begin
         for (k = 0; k < length_field; k++) begin
            r.frame_length = CNT_W'(length_field);
            r.byte_index   = CNT_W'(k);
            r.payload_byte = payload_store[k];
            r.has_payload  = 1'b1;
            r.last         = (k + 1 == length_field);
            decoded_q.push_back(r);
         end
      end
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      case (phase)
         PH_HUNT: begin
            if (b == start_byte) begin
               running_sum = b;
               phase       = PH_FUNC_HI;
            end
         end
         PH_FUNC_HI: begin
            function_code = {b, 8'h00};
            running_sum   ^= b;
            phase         = PH_FUNC_LO;
         end
         PH_FUNC_LO: begin
            function_code = {function_code[15:8], b};
            running_sum   ^= b;
            phase         = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_field = {b, 8'h00};
            running_sum  ^= b;
            phase        = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_field = {length_field[15:8], b};
            running_sum  ^= b;
            if (length_field == 0) begin
               phase = PH_CHECK;
            end else if (length_field >= MAX_PAYLOAD) begin
               phase = PH_HUNT;
            end else begin
               fill_index = 0;
               phase      = PH_DATA;
            end
         end
         PH_DATA: begin
            payload_store[fill_index] = b;
            running_sum ^= b;
            fill_index++;
            if (fill_index >= length_field)
               phase = PH_CHECK;
         end
         PH_CHECK: begin
            if (running_sum == b)
               queue_frame();
            phase = PH_HUNT;
         end
         default: begin
            phase = PH_HUNT;
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         phase         = PH_HUNT;
         start_byte    = START_BYTE_RESET;
         function_code = '0;
         length_field  = '0;
         fill_index    = 0;
         running_sum   = '0;
         decoded_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.frame_function = rsp_mon.frame_function;
            got.frame_length   = rsp_mon.frame_length;
            got.byte_index     = rsp_mon.byte_index;
            got.payload_byte   = rsp_mon.payload_byte;
            got.has_payload    = rsp_mon.has_payload;
            got.last           = rsp_mon.last;
            if (decoded_q.size() == 0) begin
               report_mismatch("result with none expected", got.frame_function, 0);
            end else begin
               want = decoded_q.pop_front();
               if (got.frame_function !== want.frame_function)
                  report_mismatch("frame_function", got.frame_function, want.frame_function);
               if (got.frame_length !== want.frame_length)
                  report_mismatch("frame_length", got.frame_length, want.frame_length);
               if (got.byte_index !== want.byte_index)
                  report_mismatch("byte_index", got.byte_index, want.byte_index);
               if (got.payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
               if (got.has_payload !== want.has_payload)
                  report_mismatch("has_payload", got.has_payload, want.has_payload);
               if (got.last !== want.last)
                  report_mismatch("last", got.last, want.last);
               results_checked++;
               if (want.last)
                  frames_checked++;
            end
         end
         // a write lands after the byte taken at the same edge
         if (csr_we)
            start_byte = csr_wdata;
      end
      pending_results = decoded_q.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Frame decoder test: directed frames (empty, start byte in the payload,
// oversize length, one byte with a bad checksum), then random traffic under
// three more start byte settings; the first two add random gaps on both channels.
// ---------------------------------------------------------------------------
module testbench;
   import sfd_pkg::*;

   localparam int MAX_PAYLOAD   = 64;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 100;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [BYTE_W-1:0] csr_wdata;

   sfd_req_if req_ch();
   sfd_rsp_if rsp_ch();

   int                mismatch_count;
   int                pending_results;
   int                results_checked;
   int                frames_checked;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                bytes_sent;
   int                cycle_count;
   logic [BYTE_W-1:0] start_byte;

   serial_frame_decoder_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) frame_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .results_checked (results_checked),
      .frames_checked  (frames_checked)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results outstanding",
                  pending_results);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      // a frame that produced nothing may still be settling
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_byte(input logic [BYTE_W-1:0] value);
      drain_results();
      csr_we     <= 1'b1;
      csr_wdata  <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      start_byte = value;
   endtask

   task automatic send_frame(input logic [FUNC_W-1:0] func, input logic [15:0] length,
                             input bit corrupt, input bit embed_start);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] data;
      int                k;
      sum = start_byte ^ func[15:8] ^ func[7:0] ^ length[15:8] ^ length[7:0];
      send_byte(start_byte);
      send_byte(func[15:8]);
      send_byte(func[7:0]);
      send_byte(length[15:8]);
      send_byte(length[7:0]);
      // oversize length drops the frame right after the header
      if (length < MAX_PAYLOAD) begin
         for (k = 0; k < length; k++) begin
            data = (k == 0 && embed_start) ? start_byte : BYTE_W'($urandom_range(255));
            sum ^= data;
            send_byte(data);
         end
         if (corrupt)
            sum ^= BYTE_W'($urandom_range(255, 1));
         send_byte(sum);
      end
   endtask

   task automatic random_traffic(input int item_budget, input bit with_full_frame);
      int          stop_at;
      int          pick;
      logic [15:0] length;
      stop_at = bytes_sent + item_budget;
      if (with_full_frame)
         send_frame(FUNC_W'($urandom), 16'(MAX_PAYLOAD - 1), 1'b0, 1'b0);
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_frame(FUNC_W'($urandom), 16'($urandom_range(12, 1)), 1'b0, pick < 8);
         end else if (pick < 65) begin
            send_frame(FUNC_W'($urandom), 16'h0000, 1'b0, 1'b0);
         end else if (pick < 75) begin
            send_frame(FUNC_W'($urandom), 16'($urandom_range(12, 0)), 1'b1, 1'b0);
         end else if (pick < 84) begin
            if ($urandom_range(1))
               length = 16'($urandom_range(255, MAX_PAYLOAD));
            else
               length = 16'($urandom_range(65535, MAX_PAYLOAD));
            send_frame(FUNC_W'($urandom), length, 1'b0, 1'b0);
         end else begin
            repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      bytes_sent     = 0;
      start_byte     = START_BYTE_RESET;
      send_idle_pct  = 34;
      recv_idle_pct  = 65;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames with the start byte left at its reset value
      send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0);
      send_frame(16'h0000, 16'h0002, 1'b0, 1'b1);
      send_frame(16'h1234, 16'(MAX_PAYLOAD), 1'b0, 1'b0);
      send_frame(16'hA55A, 16'h0001, 1'b1, 1'b0);
      drain_results();

      write_start_byte(8'h00);
      random_traffic(PHASE_ITEMS, 1'b1);

      send_idle_pct = 65;
      recv_idle_pct = 34;
      write_start_byte(8'hFF);
      random_traffic(PHASE_ITEMS, 1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_start_byte(BYTE_W'($urandom_range(254, 1)));
      random_traffic(PHASE_ITEMS, 1'b1);

      drain_results();
      $display("Sent %0d bytes under four start byte settings with varied channel gaps",
               bytes_sent);
      $display("Checked %0d results from %0d validated frames", results_checked,
               frames_checked);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
